// ----- src/imu_pkg.sv -----
// ============================================================================
// Ising Metropolis update package
// Lattice geometry, field widths, operation codes and the structs that the
// lattice, histogram and top-level modules exchange.
// ============================================================================
`default_nettype none

package imu_pkg;

  // Lattice geometry. The side is a power of two so that row and column are
  // bit fields of the site index and wrap around by plain overflow.
  localparam int unsigned SIDE    = 32;
  localparam int unsigned SIDE_W  = $clog2(SIDE);
  localparam int unsigned NSITES  = SIDE * SIDE;
  localparam int unsigned SITE_W  = 2 * SIDE_W;

  // Histogram geometry and counter width.
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned MBINS   = 2 * NSITES + 1;
  localparam int unsigned EBINS   = 4 * NSITES + 1;
  localparam int unsigned MADDR_W = $clog2(MBINS);
  localparam int unsigned EADDR_W = $clog2(EBINS);
  localparam int unsigned CLR_W   = EADDR_W;

  // Totals: magnetization spans -N..N, energy spans -2N..2N.
  localparam int unsigned MAG_W   = $clog2(NSITES) + 2;
  localparam int unsigned EN_W    = $clog2(NSITES) + 3;

  // Item fields.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned BIN_W   = 13;
  localparam int unsigned CNT_OUT_W = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_FLIP    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET     = 3'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_MAG  = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_EN   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SITE_W-1:0] site;
    logic [PROB_W-1:0] random_value;
    logic              new_spin;
    logic [BIN_W-1:0]  bin_index;
  } req_t;

  // Request held in the write-back cycle of its transaction.
  typedef struct packed {
    logic valid;
    req_t req;
  } stage_t;

  // Memory initialization sweep after reset.
  typedef struct packed {
    logic             active;
    logic [CLR_W-1:0] idx;
  } clr_t;

  typedef struct packed {
    logic             spin_now;
    logic             accepted;
    logic [MAG_W-1:0] magnetization;
    logic [EN_W-1:0]  energy;
  } lat_res_t;

endpackage

`default_nettype wire

// ----- src/imu_ram.sv -----
// ============================================================================
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module imu_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/imu_lattice.sv -----
// ============================================================================
// Ising lattice unit
// Spin rows in three identical RAM copies (rows above, at and below the
// site), Metropolis decision, row write-back and running totals.
// ============================================================================
`default_nettype none

module imu_lattice (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  imu_pkg::clr_t                clr_i,
  input  logic                         rd_en_i,
  input  imu_pkg::req_t                rd_req_i,
  input  imu_pkg::stage_t              stage_i,
  input  logic [imu_pkg::PROB_W-1:0]   prob_four_i,
  input  logic [imu_pkg::PROB_W-1:0]   prob_eight_i,
  output imu_pkg::lat_res_t            res_o,
  output logic [imu_pkg::MAG_W-1:0]    magnet_o,
  output logic [imu_pkg::EN_W-1:0]     energy_o
);

  localparam int unsigned SW = imu_pkg::SIDE_W;

  // Read side (accept cycle of a transaction).
  logic [SW-1:0] row_a;
  logic [SW-1:0] row_up_a;
  logic [SW-1:0] row_dn_a;

  // Data and decision side (write-back cycle).
  logic [imu_pkg::SIDE-1:0] row_up;
  logic [imu_pkg::SIDE-1:0] row_mid;
  logic [imu_pkg::SIDE-1:0] row_dn;
  logic [SW-1:0]            row_b;
  logic [SW-1:0]            col_b;
  logic [SW-1:0]            col_l;
  logic [SW-1:0]            col_r;
  logic                     site_ok;
  logic                     spin;
  logic [3:0]               nb;
  logic [3:0]               aligned;
  logic [2:0]               k;
  logic                     take;
  logic                     flip;
  logic [imu_pkg::EN_W-1:0] delta_e;

  logic                     we;
  logic [SW-1:0]            waddr;
  logic [imu_pkg::SIDE-1:0] wdata;

  logic [imu_pkg::MAG_W-1:0] magnet_q, magnet_d;
  logic [imu_pkg::EN_W-1:0]  energy_q, energy_d;

  assign row_a    = rd_req_i.site[imu_pkg::SITE_W-1:SW];
  assign row_up_a = row_a - SW'(1);
  assign row_dn_a = row_a + SW'(1);

  // Every copy gets the same write, each is read at its own row.
  imu_ram #(.DEPTH(imu_pkg::SIDE), .WIDTH(imu_pkg::SIDE)) u_ram_up (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en_i),
    .raddr_i (row_up_a),
    .rdata_o (row_up)
  );

  imu_ram #(.DEPTH(imu_pkg::SIDE), .WIDTH(imu_pkg::SIDE)) u_ram_mid (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en_i),
    .raddr_i (row_a),
    .rdata_o (row_mid)
  );

  imu_ram #(.DEPTH(imu_pkg::SIDE), .WIDTH(imu_pkg::SIDE)) u_ram_dn (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en_i),
    .raddr_i (row_dn_a),
    .rdata_o (row_dn)
  );

  assign row_b   = stage_i.req.site[imu_pkg::SITE_W-1:SW];
  assign col_b   = stage_i.req.site[SW-1:0];
  assign col_l   = col_b - SW'(1);
  assign col_r   = col_b + SW'(1);
  assign site_ok = 32'(stage_i.req.site) < imu_pkg::NSITES;

  assign spin    = row_mid[col_b];
  assign nb      = {row_up[col_b], row_dn[col_b], row_mid[col_l], row_mid[col_r]};
  assign aligned = ~(nb ^ {4{spin}});
  assign k       = 3'(aligned[0]) + 3'(aligned[1]) + 3'(aligned[2]) + 3'(aligned[3]);

  // The energy change of a flip is 4k - 8, k being the neighbors aligned with
  // the spin; only k of three or four costs energy.
  assign delta_e = imu_pkg::EN_W'({k, 2'b00}) - imu_pkg::EN_W'(8);

  always_comb begin
    take = 1'b0;
    priority if (stage_i.req.op == imu_pkg::OP_FLIP) begin
      priority if (k <= 3'd2) begin
        take = 1'b1;
      end else if (k == 3'd3) begin
        take = stage_i.req.random_value < prob_four_i;
      end else begin
        take = stage_i.req.random_value < prob_eight_i;
      end
    end else if (stage_i.req.op == imu_pkg::OP_SET) begin
      take = spin != stage_i.req.new_spin;
    end else begin
      take = 1'b0;
    end
  end

  assign flip = stage_i.valid && site_ok && take;

  always_comb begin
    if (clr_i.active) begin
      we    = 32'(clr_i.idx) < imu_pkg::SIDE;
      waddr = clr_i.idx[SW-1:0];
      wdata = '1;
    end else begin
      we    = flip;
      waddr = row_b;
      wdata = row_mid ^ (imu_pkg::SIDE'(1) << col_b);
    end
  end

  always_comb begin
    magnet_d = magnet_q;
    energy_d = energy_q;
    if (flip) begin
      magnet_d = spin ? magnet_q - imu_pkg::MAG_W'(2) : magnet_q + imu_pkg::MAG_W'(2);
      energy_d = energy_q + delta_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magnet_q <= imu_pkg::MAG_W'(imu_pkg::NSITES);
      energy_q <= imu_pkg::EN_W'(-2 * int'(imu_pkg::NSITES));
    end else if (stage_i.valid) begin
      magnet_q <= magnet_d;
      energy_q <= energy_d;
    end
  end

  assign res_o.spin_now      = site_ok && (spin ^ flip);
  assign res_o.accepted      = flip;
  assign res_o.magnetization = magnet_d;
  assign res_o.energy        = energy_d;

  assign magnet_o = magnet_q;
  assign energy_o = energy_q;

endmodule

`default_nettype wire

// ----- src/imu_hist.sv -----
// ============================================================================
// Ising histogram unit
// Magnetization and energy histograms in RAM: saturating increment by
// read-modify-write on a sample, bin read-back on a bin read.
// ============================================================================
`default_nettype none

module imu_hist (
  input  logic                          clk_i,
  input  imu_pkg::clr_t                 clr_i,
  input  logic                          rd_en_i,
  input  imu_pkg::req_t                 rd_req_i,
  input  imu_pkg::stage_t               stage_i,
  input  logic [imu_pkg::MAG_W-1:0]     magnet_i,
  input  logic [imu_pkg::EN_W-1:0]      energy_i,
  output logic [imu_pkg::CNT_OUT_W-1:0] bin_count_o
);

  localparam int unsigned CW = imu_pkg::COUNT_W;

  logic [imu_pkg::MADDR_W-1:0] mag_sample_addr;
  logic [imu_pkg::EADDR_W-1:0] en_sample_addr;
  logic [imu_pkg::MADDR_W-1:0] mag_raddr, mag_waddr;
  logic [imu_pkg::EADDR_W-1:0] en_raddr, en_waddr;
  logic [CW-1:0]               mag_rdata, en_rdata;
  logic [CW-1:0]               mag_wdata, en_wdata;
  logic                        mag_we, en_we;
  logic                        sample_b;
  logic [CW-1:0]               count;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == '1) ? v : v + CW'(1);
  endfunction

  // Totals do not move between the read and the write of a sample, so the
  // same bin address serves both cycles.
  assign mag_sample_addr = imu_pkg::MADDR_W'(magnet_i) + imu_pkg::MADDR_W'(imu_pkg::NSITES);
  assign en_sample_addr  = imu_pkg::EADDR_W'(energy_i) + imu_pkg::EADDR_W'(2 * imu_pkg::NSITES);

  assign mag_raddr = (rd_req_i.op == imu_pkg::OP_SAMPLE) ? mag_sample_addr :
                     rd_req_i.bin_index[imu_pkg::MADDR_W-1:0];
  assign en_raddr  = (rd_req_i.op == imu_pkg::OP_SAMPLE) ? en_sample_addr :
                     rd_req_i.bin_index[imu_pkg::EADDR_W-1:0];

  assign sample_b = stage_i.valid && (stage_i.req.op == imu_pkg::OP_SAMPLE);

  always_comb begin
    if (clr_i.active) begin
      mag_we    = 32'(clr_i.idx) < imu_pkg::MBINS;
      mag_waddr = clr_i.idx[imu_pkg::MADDR_W-1:0];
      mag_wdata = '0;
      en_we     = 1'b1;
      en_waddr  = clr_i.idx[imu_pkg::EADDR_W-1:0];
      en_wdata  = '0;
    end else begin
      mag_we    = sample_b;
      mag_waddr = mag_sample_addr;
      mag_wdata = sat_inc(mag_rdata);
      en_we     = sample_b;
      en_waddr  = en_sample_addr;
      en_wdata  = sat_inc(en_rdata);
    end
  end

  imu_ram #(.DEPTH(imu_pkg::MBINS), .WIDTH(CW)) u_ram_mag (
    .clk_i   (clk_i),
    .we_i    (mag_we),
    .waddr_i (mag_waddr),
    .wdata_i (mag_wdata),
    .re_i    (rd_en_i),
    .raddr_i (mag_raddr),
    .rdata_o (mag_rdata)
  );

  imu_ram #(.DEPTH(imu_pkg::EBINS), .WIDTH(CW)) u_ram_en (
    .clk_i   (clk_i),
    .we_i    (en_we),
    .waddr_i (en_waddr),
    .wdata_i (en_wdata),
    .re_i    (rd_en_i),
    .raddr_i (en_raddr),
    .rdata_o (en_rdata)
  );

  always_comb begin
    count = '0;
    if (stage_i.req.op == imu_pkg::OP_RD_MAG &&
        32'(stage_i.req.bin_index) < imu_pkg::MBINS) begin
      count = mag_rdata;
    end else if (stage_i.req.op == imu_pkg::OP_RD_EN &&
                 32'(stage_i.req.bin_index) < imu_pkg::EBINS) begin
      count = en_rdata;
    end
  end

  assign bin_count_o = imu_pkg::CNT_OUT_W'(count);

endmodule

`default_nettype wire

// ----- src/imu_out_fifo.sv -----
// ============================================================================
// Ising result buffer
// Two-entry output queue that decouples the update pipeline from the
// result stream.
// ============================================================================
`default_nettype none

module imu_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [imu_pkg::OUT_DATA_W-1:0] data_i,
  output logic                           full_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [imu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [imu_pkg::OUT_DATA_W-1:0] buf_q [2];
  logic                           wr_ptr_q, rd_ptr_q;
  logic [1:0]                     cnt_q, cnt_d;
  logic                           pop;

  assign pop = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o        = cnt_q == 2'd2;
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = buf_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- src/ising_metropolis_update_core.sv -----
// ============================================================================
// Ising Metropolis update core
// Single-spin Metropolis updates on a periodic 32 x 32 lattice with running
// magnetization, energy and saturating sample histograms.
// ============================================================================
// After reset the core runs an initialization sweep that sets every spin up
// and zeroes both histograms; s_axis_tready stays low during it, while
// register writes on the APB port are taken as usual. Each transaction then
// reads the spin rows and histogram bins from synchronous RAM in the accept
// cycle and writes them back in the next, and only one transaction is in
// that read-modify-write at a time, so a new one is not accepted until the
// last has been written back. Results go into a two-entry output queue, so
// the core keeps accepting while one result waits on m_axis.
`default_nettype none

module ising_metropolis_update_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] site, [25:10] random_value, [26] new_spin, [39:27] bin_index
  input  logic [imu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] op
  input  logic [imu_pkg::OP_W-1:0]       s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] spin_now, [1] accepted, [13:2] magnetization, [26:14] energy,
  // [58:27] bin_count, [63:59] zero
  output logic [imu_pkg::OUT_DATA_W-1:0] m_axis_tdata,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_PROB_FOUR  = 1'b0;
  localparam logic REG_PROB_EIGHT = 1'b1;

  logic [imu_pkg::PROB_W-1:0] prob_four_q, prob_eight_q;
  logic                       cfg_wr;

  logic                       accept;
  imu_pkg::req_t              in_req;
  imu_pkg::req_t              req_q;
  logic                       busy_q;
  imu_pkg::stage_t            stage;

  logic                       clr_q;
  logic [imu_pkg::CLR_W-1:0]  clr_idx_q;
  imu_pkg::clr_t              clr;

  imu_pkg::lat_res_t              lat_res;
  logic [imu_pkg::MAG_W-1:0]      magnet;
  logic [imu_pkg::EN_W-1:0]       energy;
  logic [imu_pkg::CNT_OUT_W-1:0]  bin_count;
  logic [imu_pkg::OUT_DATA_W-1:0] res_data;
  logic                           fifo_full;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PROB_EIGHT) ? 32'(prob_eight_q) : 32'(prob_four_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_four_q  <= '0;
      prob_eight_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PROB_FOUR) begin
        prob_four_q <= pwdata[imu_pkg::PROB_W-1:0];
      end else begin
        prob_eight_q <= pwdata[imu_pkg::PROB_W-1:0];
      end
    end
  end

  // Initialization sweep over the deepest memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      if (32'(clr_idx_q) == imu_pkg::EBINS - 1) begin
        clr_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + imu_pkg::CLR_W'(1);
      end
    end
  end

  assign clr.active = clr_q;
  assign clr.idx    = clr_idx_q;

  // Input unpacking and the request register for the write-back cycle.
  assign in_req.op           = s_axis_tuser;
  assign in_req.site         = s_axis_tdata[9:0];
  assign in_req.random_value = s_axis_tdata[25:10];
  assign in_req.new_spin     = s_axis_tdata[26];
  assign in_req.bin_index    = s_axis_tdata[39:27];

  assign s_axis_tready = !clr_q && !busy_q && !fifo_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req;
    end
  end

  assign stage.valid = busy_q;
  assign stage.req   = req_q;

  imu_lattice u_lattice (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (clr),
    .rd_en_i      (accept),
    .rd_req_i     (in_req),
    .stage_i      (stage),
    .prob_four_i  (prob_four_q),
    .prob_eight_i (prob_eight_q),
    .res_o        (lat_res),
    .magnet_o     (magnet),
    .energy_o     (energy)
  );

  imu_hist u_hist (
    .clk_i       (clk_i),
    .clr_i       (clr),
    .rd_en_i     (accept),
    .rd_req_i    (in_req),
    .stage_i     (stage),
    .magnet_i    (magnet),
    .energy_i    (energy),
    .bin_count_o (bin_count)
  );

  assign res_data = {5'b0, bin_count, lat_res.energy, lat_res.magnetization,
                     lat_res.accepted, lat_res.spin_now};

  imu_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (busy_q),
    .data_i        (res_data),
    .full_o        (fifo_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A finishing transaction always finds room in the output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (!fifo_full || (m_axis_tvalid && m_axis_tready)))
    else $error("result pushed into a full output queue");

  // No transaction may overlap the initialization sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !clr_q)
    else $error("transaction in flight during initialization sweep");

  // Magnetization stays within the lattice size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed(magnet) <= $signed(imu_pkg::MAG_W'(imu_pkg::NSITES))) &&
    ($signed(magnet) >= -$signed(imu_pkg::MAG_W'(imu_pkg::NSITES))))
    else $error("magnetization out of range");

  // The energy total stays a multiple of four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    energy[1:0] == 2'b00)
    else $error("energy not a multiple of four");

endmodule

`default_nettype wire
